>>> rtl/rleh_pkg.sv
// Package for the ring line escape heading block.
// Holds the shared widths, types, heading constants and helper functions.
// Used by rleh_lane, rleh_merge and ring_line_escape_heading.
`default_nettype none

package rleh_pkg;

    localparam int SENSOR_MAX = 12;
    localparam int IDX_W      = 4;
    localparam int LVL_W      = 3;
    localparam int LVL_COUNT  = 8;
    localparam int HEAD_W     = 10;

    localparam logic [9:0] HEADING_STEP = 10'd30;
    localparam logic [9:0] HEADING_HALF = 10'd180;
    localparam logic [9:0] HEADING_FULL = 10'd360;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [LVL_W-1:0]      t_lvl;
    typedef logic [LVL_COUNT-1:0]  t_lvl_hot;
    typedef logic [SENSOR_MAX-1:0] t_bits;
    typedef logic signed [HEAD_W-1:0] t_heading;

    typedef struct packed {
        logic any_lit;
        t_lvl max_lvl;
    } t_merge_res;

    function automatic t_idx highest_lit(input t_bits bits);
        t_idx r;
        r = '0;
        for (int i = 0; i < SENSOR_MAX; i++) begin
            if (bits[i]) begin
                r = t_idx'(i);
            end
        end
        return r;
    endfunction

    function automatic t_heading toward_of(input t_idx first);
        logic [9:0] h;
        h = 10'(first) * HEADING_STEP;
        return t_heading'(h);
    endfunction

    function automatic t_heading escape_of(input t_idx first);
        logic [9:0] h;
        h = 10'(first) * HEADING_STEP;
        if (h >= HEADING_HALF) begin
            h = h - HEADING_HALF;
        end else begin
            h = h + HEADING_HALF;
        end
        return t_heading'(h);
    endfunction

endpackage

`default_nettype wire

>>> rtl/ring_line_escape_heading.sv
// Top level of the ring line escape heading block.
// Instantiates one rleh_lane per sensor and rleh_merge; uses rleh_pkg.
//
// One sample of the sensor ring is taken per clock while the output is not stalled, and its
// result beat appears from the output register in the cycle after the sample is taken. The
// lanes each compare one sensor's ring distance against the first seen sensor in parallel,
// and the one-hot merge finds the largest danger. The input stalls only while a result beat
// is held by a stalled output.
`default_nettype none

module ring_line_escape_heading #(
    parameter int SENSOR_COUNT = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [11:0]            i_sensor_bits,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic signed [9:0]           o_heading,
    output logic [2:0]                  o_danger_level,
    input  wire logic                   i_psel,
    input  wire logic                   i_penable,
    input  wire logic                   i_pwrite,
    input  wire logic [2:0]             i_paddr,
    input  wire logic [31:0]            i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);

    localparam logic [11:0] SENSOR_MASK = 12'((13'd1 << SENSOR_COUNT) - 13'd1);

    rleh_pkg::t_lvl     r_thr;
    rleh_pkg::t_lvl     r_danger;
    rleh_pkg::t_lvl     n_danger;
    rleh_pkg::t_idx     r_first;
    rleh_pkg::t_idx     n_first;
    rleh_pkg::t_heading r_heading;
    rleh_pkg::t_heading n_heading;
    logic               r_out_valid;

    rleh_pkg::t_bits     bits_m;
    rleh_pkg::t_idx      first_cur;
    rleh_pkg::t_lvl_hot  lvl_hot [SENSOR_COUNT];
    rleh_pkg::t_merge_res merge_res;
    logic                in_take;
    logic                cfg_wr;

    assign bits_m    = i_sensor_bits & SENSOR_MASK;
    assign first_cur = (r_danger == '0) ? rleh_pkg::highest_lit(bits_m) : r_first;

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        rleh_lane #(
            .SENSOR_COUNT(SENSOR_COUNT),
            .LANE        (g)
        ) u_lane (
            .i_lit    (bits_m[g]),
            .i_first  (first_cur),
            .o_lvl_hot(lvl_hot[g])
        );
    end

    rleh_merge #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) u_merge (
        .i_lvl_hot(lvl_hot),
        .o_res    (merge_res)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_danger  = r_danger;
        n_first   = r_first;
        n_heading = rleh_pkg::escape_of(r_first);
        if (merge_res.any_lit) begin
            n_danger = merge_res.max_lvl;
            n_first  = first_cur;
            if (merge_res.max_lvl <= r_thr) begin
                n_heading = rleh_pkg::toward_of(first_cur);
            end else begin
                n_heading = rleh_pkg::escape_of(first_cur);
            end
        end else if (r_danger <= r_thr) begin
            n_danger  = '0;
            n_heading = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_danger    <= '0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_danger    <= n_danger;
                r_first     <= n_first;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_heading <= n_heading;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_heading      = r_heading;
    assign o_danger_level = r_danger;

    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == 1'b0) ? 32'(r_thr) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 3'd3;
        end else if (cfg_wr && (i_paddr[2] == 1'b0)) begin
            r_thr <= i_pwdata[2:0];
        end
    end

    a_no_line_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_heading == -10'sd1)) |-> (o_danger_level == 3'd0))
        else $error("no-line heading reported with nonzero danger");

    a_lit_sets_danger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && ((i_sensor_bits & SENSOR_MASK) != 12'd0)) |=> (r_danger != 3'd0))
        else $error("lit sample left danger at zero");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled without a held result beat");

endmodule

`default_nettype wire

>>> rtl/rleh_lane.sv
// One sensor lane: ring distance of this sensor from the first seen sensor.
// Emits the sensor's danger as a one-hot vector when the sensor is lit.
// Depends on rleh_pkg.
`default_nettype none

module rleh_lane #(
    parameter int SENSOR_COUNT = 12,
    parameter int LANE         = 0
) (
    input  wire logic             i_lit,
    input  wire rleh_pkg::t_idx   i_first,
    output rleh_pkg::t_lvl_hot    o_lvl_hot
);

    localparam logic [4:0] LANE_IDX = 5'(LANE);
    localparam logic [4:0] RING_N   = 5'(SENSOR_COUNT);

    logic [4:0]     sum;
    logic [4:0]     fwd;
    logic [4:0]     back;
    logic [4:0]     ring_gap;
    rleh_pkg::t_lvl lvl;

    always_comb begin
        sum      = LANE_IDX + RING_N - 5'(i_first);
        fwd      = (sum >= RING_N) ? (sum - RING_N) : sum;
        back     = (fwd == 5'd0) ? 5'd0 : (RING_N - fwd);
        ring_gap = (fwd < back) ? fwd : back;
        lvl      = rleh_pkg::t_lvl'(ring_gap + 5'd1);
        o_lvl_hot = i_lit ? (rleh_pkg::t_lvl_hot'(1) << lvl) : '0;
    end

endmodule

`default_nettype wire

>>> rtl/rleh_merge.sv
// Merge stage: combines the one-hot danger vectors of all lanes.
// Reports whether any sensor is lit and the largest danger among them.
// Depends on rleh_pkg.
`default_nettype none

module rleh_merge #(
    parameter int SENSOR_COUNT = 12
) (
    input  wire rleh_pkg::t_lvl_hot i_lvl_hot [SENSOR_COUNT],
    output rleh_pkg::t_merge_res    o_res
);

    rleh_pkg::t_lvl_hot acc;
    rleh_pkg::t_lvl     top;

    always_comb begin
        acc = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            acc = acc | i_lvl_hot[i];
        end
        top = '0;
        for (int v = 1; v < rleh_pkg::LVL_COUNT; v++) begin
            if (acc[v]) begin
                top = rleh_pkg::t_lvl'(v);
            end
        end
        o_res.any_lit = |acc;
        o_res.max_lvl = top;
    end

endmodule

`default_nettype wire

>>> tb/ring_line_escape_heading_tb.sv
// Self-checking testbench for the ring line escape heading block.
// Predicts heading and danger for every accepted sample and drives the APB threshold register.
// Depends on rleh_pkg and ring_line_escape_heading.
`timescale 1ns / 1ps

class heading_scoreboard;
    typedef struct {
        rleh_pkg::t_heading heading;
        rleh_pkg::t_lvl     danger;
    } t_beat;

    localparam int RING = 12;

    rleh_pkg::t_lvl  threshold;
    rleh_pkg::t_lvl  danger_now;
    rleh_pkg::t_idx  first_lit;
    rleh_pkg::t_lvl  ring_dist[RING];
    t_beat           expected_q[$];
    int              errors;

    function new();
        threshold = 3'd3;
        danger_now = '0;
        first_lit = '0;
        foreach (ring_dist[i]) ring_dist[i] = '0;
        errors = 0;
    endfunction

    function void set_threshold(rleh_pkg::t_lvl value);
        threshold = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function rleh_pkg::t_heading toward_heading();
        return rleh_pkg::t_heading'(int'(first_lit) * 30);
    endfunction

    function rleh_pkg::t_heading escape_heading();
        return rleh_pkg::t_heading'((int'(first_lit) * 30 + 180) % 360);
    endfunction

    function void note_sample(rleh_pkg::t_bits bits);
        int              fwd;
        int              back;
        int              ring_gap;
        rleh_pkg::t_lvl  peak;
        t_beat           b;
        if (bits != '0) begin
            if (danger_now == '0) begin
                for (int i = 0; i < RING; i++) begin
                    if (bits[i]) first_lit = rleh_pkg::t_idx'(i);
                end
                for (int i = 0; i < RING; i++) begin
                    fwd = (i + RING - int'(first_lit)) % RING;
                    back = (RING - fwd) % RING;
                    ring_gap = (fwd < back) ? fwd : back;
                    ring_dist[i] = rleh_pkg::t_lvl'(ring_gap + 1);
                end
            end
            peak = '0;
            for (int i = 0; i < RING; i++) begin
                if (bits[i] && ring_dist[i] > peak) peak = ring_dist[i];
            end
            danger_now = peak;
            b.heading = (danger_now <= threshold) ? toward_heading() : escape_heading();
        end else if (danger_now <= threshold) begin
            b.heading = -10'sd1;
            foreach (ring_dist[i]) ring_dist[i] = '0;
            danger_now = '0;
        end else begin
            b.heading = escape_heading();
        end
        b.danger = danger_now;
        expected_q.push_back(b);
    endfunction

    function void check_beat(rleh_pkg::t_heading heading, rleh_pkg::t_lvl danger);
        t_beat b;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, heading %0d danger %0d",
                     $time, heading, danger);
            return;
        end
        b = expected_q.pop_front();
        if (heading !== b.heading) begin
            errors++;
            $display("%0t: heading mismatch, expected %0d actual %0d",
                     $time, b.heading, heading);
        end
        if (danger !== b.danger) begin
            errors++;
            $display("%0t: danger mismatch, expected %0d actual %0d",
                     $time, b.danger, danger);
        end
    endfunction
endclass

module ring_line_escape_heading_tb;

    localparam logic [2:0] ADDR_ESCAPE_THRESHOLD = 3'd0;
    localparam int SEGMENTS = 9;
    localparam int SEGMENT_ITEMS = 182;
    localparam int LONG_HOLD = 200;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    rleh_pkg::t_bits     i_sensor_bits;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    rleh_pkg::t_heading  o_heading;
    rleh_pkg::t_lvl      o_danger_level;
    logic                i_psel;
    logic                i_penable;
    logic                i_pwrite;
    logic [2:0]          i_paddr;
    logic [31:0]         i_pwdata;
    logic [31:0]         o_prdata;
    logic                o_pready;

    heading_scoreboard sb;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int   hold_left = 0;
    int   ep_center = 0;
    int   ep_left = 0;

    ring_line_escape_heading dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sensor_bits  (i_sensor_bits),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_heading      (o_heading),
        .o_danger_level (o_danger_level),
        .i_psel         (i_psel),
        .i_penable      (i_penable),
        .i_pwrite       (i_pwrite),
        .i_paddr        (i_paddr),
        .i_pwdata       (i_pwdata),
        .o_prdata       (o_prdata),
        .o_pready       (o_pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Outputs are sampled on the falling edge ahead of the rising edge at which the beat moves.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_beat(o_heading, o_danger_level);
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic rleh_pkg::t_bits ring_band(int center, int width);
        rleh_pkg::t_bits b;
        b = '0;
        for (int k = 0; k < width; k++) b[(center + k) % 12] = 1'b1;
        return b;
    endfunction

    // A line pass is a lost-line sample followed by a band that drifts around the ring; random words are mixed in.
    function automatic rleh_pkg::t_bits pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12) return rleh_pkg::t_bits'($urandom);
        if (ep_left == 0) begin
            ep_left = $urandom_range(10, 2);
            ep_center = $urandom_range(11);
            return '0;
        end
        ep_left--;
        roll = $urandom_range(9);
        if (roll >= 8) ep_center = $urandom_range(11);
        else if (roll >= 5) ep_center = (ep_center + ((roll == 5) ? 11 : 1)) % 12;
        return ring_band(ep_center, $urandom_range(3, 1));
    endfunction

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= addr;
        i_pwdata <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(negedge i_clk); while (!o_pready);
        @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_read_check(input logic [2:0] addr, input logic [31:0] want);
        logic [31:0] got;
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        i_paddr <= addr;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(negedge i_clk); while (!o_pready);
        got = o_prdata;
        @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
        if (got !== want) begin
            sb.errors++;
            $display("%0t: register read mismatch, expected %0d actual %0d", $time, want, got);
        end
    endtask

    task automatic send_sample(input rleh_pkg::t_bits bits);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sensor_bits <= bits;
        do @(negedge i_clk); while (o_in_stall);
        sb.note_sample(bits);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        rleh_pkg::t_bits directed[$];
        rleh_pkg::t_lvl  seg_threshold[SEGMENTS];

        sb = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_sensor_bits <= '0;
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        i_paddr <= '0;
        i_pwdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_read_check(ADDR_ESCAPE_THRESHOLD, 32'd3);

        // Covers lost line at low and high danger, the opposite of sensor 6 and all lit.
        directed = '{12'h000, 12'h001, 12'h000, 12'h800, 12'h020, 12'h000, 12'h000,
                     12'h800, 12'h000, 12'h040, 12'h001, 12'h000, 12'hFFF, 12'h040,
                     12'h000, 12'hFFF, 12'h400, 12'h200, 12'h100, 12'h000, 12'h800,
                     12'h000, 12'h555, 12'hAAA, 12'h000};
        foreach (directed[i]) send_sample(directed[i]);
        i_in_valid <= 1'b0;
        wait_drained();

        seg_threshold = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd2, 3'd5, 3'd4, 3'd6, 3'd1};
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            cfg_write(ADDR_ESCAPE_THRESHOLD, 32'(seg_threshold[seg]));
            sb.set_threshold(seg_threshold[seg]);
            cfg_read_check(ADDR_ESCAPE_THRESHOLD, 32'(seg_threshold[seg]));
            @(negedge i_clk);
            tx_idle_pct = (seg < 3) ? 26 : (seg < 6) ? 79 : 0;
            rx_idle_pct = (seg < 3) ? 79 : (seg < 6) ? 26 : 0;
            if (seg == 6) hold_req = ~hold_req;
            @(posedge i_clk);
            for (int n = 0; n < SEGMENT_ITEMS; n++) send_sample(pick_sample());
            i_in_valid <= 1'b0;
            wait_drained();
        end

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
